>>> hw/rtl/inverse_distance_weight_row_macros.svh
// ----------------------------------------------------------------------------
// Inverse distance weight row: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INVERSE_DISTANCE_WEIGHT_ROW_MACROS_SVH
`define INVERSE_DISTANCE_WEIGHT_ROW_MACROS_SVH

// same-cycle implication
`define IDWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IDWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/idwr_pkg.sv
// ----------------------------------------------------------------------------
// idwr_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idwr_pkg;

  localparam int unsigned MAX_POINTS = 32;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned W_W        = 32;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned ACC_W      = 66;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b1;

  localparam logic [W_W-1:0] EMIT_SCALE    = 32'd10000000;
  localparam logic [W_W-1:0] ONE_Q31       = 32'h8000_0000;
  localparam logic [63:0]    SPECIAL_LIMIT = 64'h0000_0002_0000_0000;

  typedef enum logic [1:0] {
    MUL_DX = 2'd0,
    MUL_DY = 2'd1,
    MUL_DZ = 2'd2,
    MUL_W  = 2'd3
  } mul_sel_e;

  typedef enum logic [1:0] {
    INV_SPECIAL = 2'd0,
    INV_ONES    = 2'd1,
    INV_QUOT    = 2'd2
  } inv_src_e;

  typedef enum logic {
    DIV_RECIP = 1'b0,
    DIV_NORM  = 1'b1
  } div_sel_e;

  typedef enum logic [1:0] {
    OUT_PEND      = 2'd0,
    OUT_PEND_LAST = 2'd1,
    OUT_EMPTY     = 2'd2,
    OUT_HIT       = 2'd3
  } out_src_e;

  typedef struct packed {
    logic     ld_point;
    logic     q_ld;
    logic     idx_clr;
    logic     idx_inc;
    logic     fetch_pt;
    logic     diff_ld;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     sqrt_start;
    logic     div_start;
    div_sel_e div_sel;
    logic     inv_ld;
    inv_src_e inv_src;
    logic     accum;
    logic     fetch_w;
    logic     pend_ld;
    logic     out_ld;
    out_src_e out_src;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic coincident;
    logic carry_zero;
    logic root_one;
    logic sqrt_busy;
    logic div_busy;
    logic keep;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/inverse_distance_weight_row.sv
// ----------------------------------------------------------------------------
// inverse_distance_weight_row
// Inverse distance weight row generator for point cloud to lattice mapping.
//
// Input channel (in_valid_i / in_stall_o): a load beat (op 0) writes one
// cloud point into its slot and gives no result. A query beat (op 1)
// gives one lattice node; input then stalls until the query is done.
// Weight pass: per point, the squares of three differences on one shared
// multiplier, a square root and a reciprocal divide; a coincident point
// ends the weight pass early.
// Normalise pass: per point a scaled compare, and per emitted result a
// divide on the shared divider.
// Output channel (out_valid_o / out_stall_i): one beat per kept point in
// index order, last on the final one, one empty-row beat, or one hit beat
// for a coincident point. A result register and a pending-result register
// sit between the pass and the port, so a stalled receiver only holds a
// kept-point push when both are full. Configuration (cfg_valid_i /
// cfg_ready_o) is always ready; write only while idle. Reset clears the
// control registers, the sequencer and the output; the point store holds
// nothing until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "inverse_distance_weight_row_macros.svh"

module inverse_distance_weight_row (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                in_op_i,
  input  wire logic [idwr_pkg::IDX_W-1:0]          in_point_slot_i,
  input  wire logic signed [idwr_pkg::COORD_W-1:0] in_pos_x_i,
  input  wire logic signed [idwr_pkg::COORD_W-1:0] in_pos_y_i,
  input  wire logic signed [idwr_pkg::COORD_W-1:0] in_pos_z_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [idwr_pkg::IDX_W-1:0]               out_column_o,
  output logic [idwr_pkg::W_W-1:0]                 out_weight_o,
  output logic                                     out_empty_row_o,
  output logic                                     out_last_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [idwr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [idwr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import idwr_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  idwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_op_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  idwr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .point_slot_i    (in_point_slot_i),
    .pos_x_i         (in_pos_x_i),
    .pos_y_i         (in_pos_y_i),
    .pos_z_i         (in_pos_z_i),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_column_o    (out_column_o),
    .out_weight_o    (out_weight_o),
    .out_empty_row_o (out_empty_row_o),
    .out_last_o      (out_last_o)
  );

  `IDWR_ASSERT_NOW(a_no_overwrite, cmd.out_ld, status.out_free, "result beat overwritten")
  `IDWR_ASSERT_NOW(a_unit_idle, cmd.sqrt_start || cmd.div_start, !status.sqrt_busy && !status.div_busy, "iterative unit restarted while busy")
  `IDWR_ASSERT_NOW(a_empty_last, out_valid_o && out_empty_row_o, out_last_o && out_weight_o == '0, "empty row beat malformed")
  `IDWR_ASSERT_NEXT(a_weight_range, cmd.out_ld, out_weight_o <= ONE_Q31, "weight above one")

endmodule

`default_nettype wire

>>> hw/rtl/idwr_sqrt.sv
// ----------------------------------------------------------------------------
// idwr_sqrt
// Iterative integer square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idwr_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic             busy_o,
  output logic [31:0]      root_o
);
  import idwr_pkg::*;

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] s_q, s_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [34:0] t, trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    s_d    = s_q;
    rem_d  = rem_q;
    root_d = root_q;
    t      = {rem_q, s_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      s_d    = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      s_d = {s_q[61:0], 2'b00};
      if (t >= trial) begin
        rem_d  = 33'(t - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = t[32:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> hw/rtl/idwr_div.sv
// ----------------------------------------------------------------------------
// idwr_div
// Restoring divider, one quotient bit a cycle, 32-bit quotient.
// The upper dividend word must be below the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idwr_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                num_hi_i,
  input  wire logic [31:0]                num_lo_i,
  input  wire logic [idwr_pkg::SUM_W-1:0] den_i,
  output logic                            busy_o,
  output logic [31:0]                     quot_o
);
  import idwr_pkg::*;

  logic             busy_q, busy_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] den_q, den_d;
  logic [31:0]      lo_q, lo_d;
  logic [31:0]      quot_q, quot_d;
  logic [SUM_W:0]   t;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    t      = {rem_q, lo_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = {{(SUM_W-32){1'b0}}, num_hi_i};
      den_d  = den_i;
      lo_d   = num_lo_i;
      quot_d = '0;
    end else if (busy_q) begin
      lo_d = {lo_q[30:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        rem_d  = SUM_W'(t - {1'b0, den_q});
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = t[SUM_W-1:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/idwr_datapath.sv
// ----------------------------------------------------------------------------
// idwr_datapath
// Point store, distance arithmetic, weight store, sum and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idwr_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire idwr_pkg::cmd_t                  cmd_i,
  output idwr_pkg::status_t                    status_o,
  input  wire logic [idwr_pkg::IDX_W-1:0]      point_slot_i,
  input  wire logic signed [idwr_pkg::COORD_W-1:0] pos_x_i,
  input  wire logic signed [idwr_pkg::COORD_W-1:0] pos_y_i,
  input  wire logic signed [idwr_pkg::COORD_W-1:0] pos_z_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [idwr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [idwr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            out_stall_i,
  output logic                                 out_valid_o,
  output logic [idwr_pkg::IDX_W-1:0]           out_column_o,
  output logic [idwr_pkg::W_W-1:0]             out_weight_o,
  output logic                                 out_empty_row_o,
  output logic                                 out_last_o
);
  import idwr_pkg::*;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  logic [3*COORD_W-1:0] cloud_mem [MAX_POINTS];
  logic [W_W-1:0]       raw_mem   [MAX_POINTS];

  logic [W_W-1:0]       cutoff_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     n_lim;
  logic [CNT_W-1:0]     idx_q;
  logic [3*COORD_W-1:0] qpos_q;
  logic [3*COORD_W-1:0] pt_q;
  logic [COORD_W-1:0]   d_q [3];
  logic [63:0]          prod_q;
  logic [ACC_W-1:0]     acc_q;
  logic [W_W-1:0]       inv_q;
  logic [W_W-1:0]       w_q;
  logic [SUM_W-1:0]     sum_q;
  logic                 pend_valid_q;
  logic [IDX_W-1:0]     pend_col_q;
  logic [W_W-1:0]       pend_w_q;
  logic                 out_valid_q;
  logic [IDX_W-1:0]     out_col_q;
  logic [W_W-1:0]       out_w_q;
  logic                 out_empty_q;
  logic                 out_last_q;

  logic [W_W-1:0]   mul_a, mul_b;
  logic [W_W-1:0]   inv_sel;
  logic [W_W-1:0]   w_new;
  logic             w_pos;
  logic [31:0]      root;
  logic [31:0]      quot;
  logic             sqrt_busy, div_busy;
  logic [31:0]      div_hi, div_lo;
  logic [SUM_W-1:0] div_den;
  logic             out_free;

  assign n_lim = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CUTOFF: cutoff_q <= cfg_data_i;
        CFG_COUNT:  count_q  <= cfg_data_i[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_point) begin
      cloud_mem[point_slot_i] <= {pos_x_i, pos_y_i, pos_z_i};
    end
    if (cmd_i.fetch_pt) begin
      pt_q <= cloud_mem[idx_q[IDX_W-1:0]];
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_DX:  begin mul_a = d_q[0]; mul_b = d_q[0]; end
      MUL_DY:  begin mul_a = d_q[1]; mul_b = d_q[1]; end
      MUL_DZ:  begin mul_a = d_q[2]; mul_b = d_q[2]; end
      default: begin mul_a = w_q;    mul_b = EMIT_SCALE; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_ld) begin
      qpos_q <= {pos_x_i, pos_y_i, pos_z_i};
    end
    if (cmd_i.diff_ld) begin
      d_q[0] <= abs_diff(pt_q[3*COORD_W-1:2*COORD_W], qpos_q[3*COORD_W-1:2*COORD_W]);
      d_q[1] <= abs_diff(pt_q[2*COORD_W-1:COORD_W], qpos_q[2*COORD_W-1:COORD_W]);
      d_q[2] <= abs_diff(pt_q[COORD_W-1:0], qpos_q[COORD_W-1:0]);
    end
    if (cmd_i.mul_en) begin
      prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
    end
    if (cmd_i.diff_ld) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + {{(ACC_W-64){1'b0}}, prod_q};
    end
  end

  idwr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (acc_q[63:0]),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  always_comb begin
    case (cmd_i.div_sel)
      DIV_RECIP: begin
        div_hi  = 32'd1;
        div_lo  = 32'd0;
        div_den = {{(SUM_W-32){1'b0}}, root};
      end
      default: begin
        div_hi  = {1'b0, w_q[W_W-1:1]};
        div_lo  = {w_q[0], 31'd0};
        div_den = sum_q;
      end
    endcase
  end

  idwr_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_hi_i (div_hi),
    .num_lo_i (div_lo),
    .den_i    (div_den),
    .busy_o   (div_busy),
    .quot_o   (quot)
  );

  always_comb begin
    case (cmd_i.inv_src)
      INV_SPECIAL: inv_sel = (acc_q[65:64] == 2'd1 && acc_q[63:0] <= SPECIAL_LIMIT)
                             ? W_W'(1) : '0;
      INV_ONES:    inv_sel = '1;
      default:     inv_sel = quot;
    endcase
  end

  assign w_pos = inv_q > cutoff_q;
  assign w_new = w_pos ? inv_q - cutoff_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.inv_ld) begin
      inv_q <= inv_sel;
    end
    if (cmd_i.accum) begin
      raw_mem[idx_q[IDX_W-1:0]] <= w_new;
    end
    if (cmd_i.fetch_w) begin
      w_q <= raw_mem[idx_q[IDX_W-1:0]];
    end
    if (cmd_i.pend_ld) begin
      pend_col_q <= idx_q[IDX_W-1:0];
      pend_w_q   <= quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      sum_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cmd_i.q_ld || cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc || cmd_i.accum) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.q_ld) begin
        sum_q <= '0;
      end else if (cmd_i.accum) begin
        sum_q <= sum_q + {{(SUM_W-W_W){1'b0}}, w_new};
      end
      if (cmd_i.q_ld) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.pend_ld) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      case (cmd_i.out_src)
        OUT_PEND: begin
          out_col_q <= pend_col_q; out_w_q <= pend_w_q;
          out_empty_q <= 1'b0; out_last_q <= 1'b0;
        end
        OUT_PEND_LAST: begin
          out_col_q <= pend_col_q; out_w_q <= pend_w_q;
          out_empty_q <= 1'b0; out_last_q <= 1'b1;
        end
        OUT_EMPTY: begin
          out_col_q <= '0; out_w_q <= '0;
          out_empty_q <= 1'b1; out_last_q <= 1'b1;
        end
        default: begin
          out_col_q <= idx_q[IDX_W-1:0]; out_w_q <= ONE_Q31;
          out_empty_q <= 1'b0; out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign status_o.idx_end    = idx_q >= n_lim;
  assign status_o.coincident = acc_q == '0;
  assign status_o.carry_zero = acc_q[65:64] == 2'd0;
  assign status_o.root_one   = root == 32'd1;
  assign status_o.sqrt_busy  = sqrt_busy;
  assign status_o.div_busy   = div_busy;
  assign status_o.keep       = (w_q != '0) && (prod_q > {{(64-SUM_W){1'b0}}, sum_q});
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  assign out_valid_o     = out_valid_q;
  assign out_column_o    = out_col_q;
  assign out_weight_o    = out_w_q;
  assign out_empty_row_o = out_empty_q;
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/idwr_ctrl.sv
// ----------------------------------------------------------------------------
// idwr_ctrl
// Sequencer for the weight pass and the normalise-and-emit pass of a query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idwr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_op_i,
  output logic                   in_stall_o,
  input  wire idwr_pkg::status_t status_i,
  output idwr_pkg::cmd_t         cmd_o
);
  import idwr_pkg::*;

  typedef enum logic [22:0] {
    ST_IDLE       = 23'd1 << 0,
    ST_P1_CHECK   = 23'd1 << 1,
    ST_FETCH      = 23'd1 << 2,
    ST_DIFF       = 23'd1 << 3,
    ST_SQ0        = 23'd1 << 4,
    ST_SQ1        = 23'd1 << 5,
    ST_SQ2        = 23'd1 << 6,
    ST_SQ3        = 23'd1 << 7,
    ST_CLASS      = 23'd1 << 8,
    ST_SQRT_GO    = 23'd1 << 9,
    ST_SQRT_WAIT  = 23'd1 << 10,
    ST_RECIP_GO   = 23'd1 << 11,
    ST_RECIP_WAIT = 23'd1 << 12,
    ST_ACCUM      = 23'd1 << 13,
    ST_HIT_EMIT   = 23'd1 << 14,
    ST_P2_CHECK   = 23'd1 << 15,
    ST_P2_FETCH   = 23'd1 << 16,
    ST_P2_MUL     = 23'd1 << 17,
    ST_P2_CMP     = 23'd1 << 18,
    ST_DIV_GO     = 23'd1 << 19,
    ST_DIV_WAIT   = 23'd1 << 20,
    ST_P2_PUSH    = 23'd1 << 21,
    ST_FINISH     = 23'd1 << 22
  } state_e;

  state_e state_q, state_d;
  logic   idle;

  assign idle       = state_q == ST_IDLE;
  assign in_stall_o = !idle;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_DX;
    cmd_o.div_sel = DIV_RECIP;
    cmd_o.inv_src = INV_SPECIAL;
    cmd_o.out_src = OUT_PEND;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_QUERY) begin
            cmd_o.q_ld = 1'b1;
            state_d    = ST_P1_CHECK;
          end else begin
            cmd_o.ld_point = 1'b1;
          end
        end
      end
      ST_P1_CHECK: begin
        if (status_i.idx_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_P2_CHECK;
        end else begin
          cmd_o.fetch_pt = 1'b1;
          state_d        = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff_ld = 1'b1;
        state_d       = ST_SQ0;
      end
      ST_SQ0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DX;
        state_d       = ST_SQ1;
      end
      ST_SQ1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DY;
        cmd_o.acc_en  = 1'b1;
        state_d       = ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DZ;
        cmd_o.acc_en  = 1'b1;
        state_d       = ST_SQ3;
      end
      ST_SQ3: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_CLASS;
      end
      ST_CLASS: begin
        if (status_i.coincident) begin
          state_d = ST_HIT_EMIT;
        end else if (status_i.carry_zero) begin
          state_d = ST_SQRT_GO;
        end else begin
          cmd_o.inv_ld  = 1'b1;
          cmd_o.inv_src = INV_SPECIAL;
          state_d       = ST_ACCUM;
        end
      end
      ST_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (!status_i.sqrt_busy) begin
          state_d = ST_RECIP_GO;
        end
      end
      ST_RECIP_GO: begin
        if (status_i.root_one) begin
          cmd_o.inv_ld  = 1'b1;
          cmd_o.inv_src = INV_ONES;
          state_d       = ST_ACCUM;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_RECIP;
          state_d         = ST_RECIP_WAIT;
        end
      end
      ST_RECIP_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.inv_ld  = 1'b1;
          cmd_o.inv_src = INV_QUOT;
          state_d       = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_P1_CHECK;
      end
      ST_HIT_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.out_src = OUT_HIT;
          state_d       = ST_IDLE;
        end
      end
      ST_P2_CHECK: begin
        if (status_i.idx_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.fetch_w = 1'b1;
          state_d       = ST_P2_FETCH;
        end
      end
      ST_P2_FETCH: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_W;
        state_d       = ST_P2_MUL;
      end
      ST_P2_MUL: begin
        state_d = ST_P2_CMP;
      end
      ST_P2_CMP: begin
        if (status_i.keep) begin
          state_d = ST_DIV_GO;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_P2_CHECK;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_NORM;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = ST_P2_PUSH;
        end
      end
      ST_P2_PUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.out_ld  = status_i.pend_valid;
          cmd_o.out_src = OUT_PEND;
          cmd_o.pend_ld = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_P2_CHECK;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.out_src = status_i.pend_valid ? OUT_PEND_LAST : OUT_EMPTY;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_inverse_distance_weight_row.sv
// ----------------------------------------------------------------------------
// Inverse distance weight row testbench
// Loads cloud points and queries lattice nodes. Every result beat is checked
// field by field against a bit-exact model of the weight row, kept in this
// file. A short directed table covers the empty row, coincident points,
// the saturated reciprocal, coordinate extremes and cutoff extremes. Random
// phases then follow with varied cutoff and point count and random idling
// on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_inverse_distance_weight_row;
  import idwr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned RANDOM_ITEMS   = 100;

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [W_W-1:0]   weight;
    logic             empty_row;
    logic             last;
  } row_beat_t;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      op;
    logic [IDX_W-1:0]          slot;
    logic signed [COORD_W-1:0] x, y, z;
    logic                      typed;
    row_beat_t                 beat;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic in_op_i = OP_LOAD;
  logic [IDX_W-1:0] in_point_slot_i = '0;
  logic signed [COORD_W-1:0] in_pos_x_i = '0;
  logic signed [COORD_W-1:0] in_pos_y_i = '0;
  logic signed [COORD_W-1:0] in_pos_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IDX_W-1:0] out_column_o;
  logic [W_W-1:0] out_weight_o;
  logic out_empty_row_o;
  logic out_last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_CUTOFF;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  inverse_distance_weight_row u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_op_i, .in_point_slot_i,
    .in_pos_x_i, .in_pos_y_i, .in_pos_z_i,
    .out_valid_o, .out_stall_i, .out_column_o, .out_weight_o,
    .out_empty_row_o, .out_last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  logic [CFG_DATA_W-1:0]     cutoff_q;
  logic [CNT_W-1:0]          count_q;
  logic signed [COORD_W-1:0] cloud_x[MAX_POINTS];
  logic signed [COORD_W-1:0] cloud_y[MAX_POINTS];
  logic signed [COORD_W-1:0] cloud_z[MAX_POINTS];
  logic [MAX_POINTS-1:0]     loaded_q = '0;

  row_beat_t   pending_rows[$];
  stim_row_t   table_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  logic        quiet = 1'b0;

  function automatic void expect_row(row_beat_t b);
    pending_rows = {pending_rows, b};
  endfunction

  function automatic void table_add(stim_row_t r);
    table_q = {table_q, r};
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, bitv, v;
    res = '0;
    v = s;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] inv_distance(int p, logic signed [31:0] qx,
                                               logic signed [31:0] qy,
                                               logic signed [31:0] qz,
                                               output logic same);
    logic signed [32:0] d[3];
    logic [66:0] s, a;
    logic [63:0] root_v;
    d[0] = {cloud_x[p][31], cloud_x[p]} - {qx[31], qx};
    d[1] = {cloud_y[p][31], cloud_y[p]} - {qy[31], qy};
    d[2] = {cloud_z[p][31], cloud_z[p]} - {qz[31], qz};
    s = '0;
    same = 1'b0;
    for (int k = 0; k < 3; k++) begin
      a = (d[k] < 0) ? 67'(-d[k]) : 67'(d[k]);
      s = s + a * a;
    end
    if (s[66:64] == 0) begin
      if (s == 0) begin
        same = 1'b1;
        return 32'hFFFF_FFFF;
      end
      root_v = int_sqrt(s[63:0]);
      if (root_v == 1) return 32'hFFFF_FFFF;
      return 32'((64'h1_0000_0000) / root_v);
    end
    if (s[66:64] == 1 && s[63:0] < SPECIAL_LIMIT + 1) return 32'd1;
    return 32'd0;
  endfunction

  function automatic void predict_row(logic signed [31:0] qx, logic signed [31:0] qy,
                                      logic signed [31:0] qz);
    int n, hit, emitted;
    logic [31:0] raw[MAX_POINTS];
    logic [31:0] inv;
    logic [SUM_W-1:0] sum;
    logic [63:0] w;
    logic same;
    row_beat_t b;
    n = (count_q > MAX_POINTS) ? MAX_POINTS : count_q;
    hit = -1;
    emitted = 0;
    sum = '0;
    for (int i = 0; i < MAX_POINTS; i++) raw[i] = '0;
    for (int i = 0; i < n; i++) begin
      inv = inv_distance(i, qx, qy, qz, same);
      if (same) begin
        hit = i;
        break;
      end
      if (inv > cutoff_q) begin
        raw[i] = inv - cutoff_q;
        sum = sum + raw[i];
      end
    end
    if (hit >= 0) begin
      expect_row('{IDX_W'(hit), ONE_Q31, 1'b0, 1'b1});
      return;
    end
    if (sum != 0) begin
      for (int i = 0; i < n; i++) begin
        w = raw[i];
        if (w != 0 && w * EMIT_SCALE > sum) begin
          b = '{IDX_W'(i), W_W'((w << 31) / sum), 1'b0, 1'b0};
          expect_row(b);
          emitted++;
        end
      end
    end
    if (emitted == 0) expect_row('{'0, '0, 1'b1, 1'b1});
    else pending_rows[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 35);
    end
  end

  always @(posedge clk_i) begin
    row_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected beat column %0d", out_column_o));
      end else begin
        want = pending_rows.pop_front();
        if (out_column_o !== want.column)
          report_mismatch($sformatf("column %0d, want %0d", out_column_o, want.column));
        if (out_weight_o !== want.weight)
          report_mismatch($sformatf("weight %h, want %h", out_weight_o, want.weight));
        if (out_empty_row_o !== want.empty_row)
          report_mismatch($sformatf("empty_row %b, want %b", out_empty_row_o,
                                    want.empty_row));
        if (out_last_o !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_last_o, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (index == CFG_CUTOFF) cutoff_q = data;
    else count_q = data[CNT_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic send_beat(stim_row_t r);
    while (!quiet && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_op_i <= r.op;
    in_point_slot_i <= r.slot;
    in_pos_x_i <= r.x;
    in_pos_y_i <= r.y;
    in_pos_z_i <= r.z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (r.op == OP_LOAD) begin
      cloud_x[r.slot] = r.x;
      cloud_y[r.slot] = r.y;
      cloud_z[r.slot] = r.z;
      loaded_q[r.slot] = 1'b1;
    end else if (r.typed) begin
      expect_row(r.beat);
    end else begin
      predict_row(r.x, r.y, r.z);
    end
  endtask

  function automatic stim_row_t make_item(logic op, logic [IDX_W-1:0] slot,
                                          logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z);
    stim_row_t r;
    r = '{kind: ROW_ITEM, cfg_index: CFG_CUTOFF, cfg_data: '0, op: op, slot: slot,
          x: x, y: y, z: z, typed: 1'b0, beat: '0};
    return r;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = make_item(OP_LOAD, '0, '0, '0, '0);
    r.kind = ROW_CFG;
    r.cfg_index = index;
    r.cfg_data = data;
    table_add(r);
  endfunction

  function automatic void add_item(logic op, logic [IDX_W-1:0] slot, logic signed [31:0] x,
                                   logic signed [31:0] y, logic signed [31:0] z);
    table_add(make_item(op, slot, x, y, z));
  endfunction

  function automatic void add_typed(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, row_beat_t b);
    stim_row_t r;
    r = make_item(OP_QUERY, '0, x, y, z);
    r.typed = 1'b1;
    r.beat = b;
    table_add(r);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'($urandom);
      default: return 32'($urandom_range(0, 2 ** 21 - 1)) - 32'sd1048576;
    endcase
  endfunction

  function automatic logic [31:0] rand_cutoff();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0000_4000);
    endcase
  endfunction

  initial begin
    int n, p, phase;
    logic signed [31:0] qx, qy, qz;

    add_cfg(CFG_CUTOFF, 32'h0);
    add_cfg(CFG_COUNT, 32'd0);
    add_typed('0, '0, '0, '{'0, '0, 1'b1, 1'b1});
    add_item(OP_LOAD, 5'd0, 32'sh0001_0000, '0, '0);
    add_item(OP_LOAD, 5'd1, '0, 32'sh0002_0000, '0);
    add_item(OP_LOAD, 5'd2, -32'sh0003_0000, '0, '0);
    add_item(OP_LOAD, 5'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_item(OP_LOAD, 5'd31, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_cfg(CFG_COUNT, 32'd4);
    add_item(OP_QUERY, '0, '0, '0, '0);
    add_typed('0, 32'sh0002_0000, '0, '{5'd1, ONE_Q31, 1'b0, 1'b1});
    add_item(OP_QUERY, '0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_item(OP_QUERY, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
    add_item(OP_QUERY, '0, 32'sh0001_0001, '0, '0);
    add_item(OP_QUERY, '0, 32'sh0000_8000, 32'sh0000_4000, -32'sh0000_2000);
    add_cfg(CFG_CUTOFF, 32'hFFFF_FFFF);
    add_typed('0, '0, 32'sh0000_1000, '{'0, '0, 1'b1, 1'b1});
    add_typed(32'sh0001_0000, '0, '0, '{5'd0, ONE_Q31, 1'b0, 1'b1});
    add_cfg(CFG_CUTOFF, 32'h0000_8000);
    add_item(OP_QUERY, '0, 32'sh0000_4000, 32'sh0000_4000, '0);
    add_item(OP_QUERY, '0, -32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0100);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (table_q[i]) begin
      if (table_q[i].kind == ROW_CFG) begin
        drain();
        write_reg(table_q[i].cfg_index, table_q[i].cfg_data);
      end else begin
        send_beat(table_q[i]);
      end
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      quiet = (phase == 1);
      case (phase)
        3: n = 63;
        4: n = 32;
        default: n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      endcase
      write_reg(CFG_CUTOFF, rand_cutoff());
      for (int s = 0; s < ((n > MAX_POINTS) ? MAX_POINTS : n); s++)
        if (!loaded_q[s] || $urandom_range(0, 3) == 0)
          send_beat(make_item(OP_LOAD, IDX_W'(s), rand_coord(), rand_coord(), rand_coord()));
      write_reg(CFG_COUNT, n);
      for (int k = 0; k < 8; k++) begin
        if (phase == 2 && k == 4) drain();
        if ($urandom_range(0, 99) < 35) begin
          send_beat(make_item(OP_LOAD, IDX_W'($urandom_range(0, MAX_POINTS - 1)),
                              rand_coord(), rand_coord(), rand_coord()));
        end else begin
          p = (n == 0) ? 0 : $urandom_range(0, ((n > MAX_POINTS) ? MAX_POINTS : n) - 1);
          qx = loaded_q[p] ? cloud_x[p] : '0;
          qy = loaded_q[p] ? cloud_y[p] : '0;
          qz = loaded_q[p] ? cloud_z[p] : '0;
          case ($urandom_range(0, 5))
            0: ;
            1: begin
              qx = rand_coord();
              qy = rand_coord();
              qz = rand_coord();
            end
            default: begin
              qx = qx + 32'($urandom_range(0, 2 ** 18)) - 32'sd131072;
              qy = qy + 32'($urandom_range(0, 2 ** 18)) - 32'sd131072;
              qz = qz + 32'($urandom_range(0, 2 ** 10));
            end
          endcase
          send_beat(make_item(OP_QUERY, IDX_W'($urandom), qx, qy, qz));
        end
      end
      phase++;
    end

    quiet = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/idwr_pkg.sv
hw/rtl/idwr_sqrt.sv
hw/rtl/idwr_div.sv
hw/rtl/idwr_datapath.sv
hw/rtl/idwr_ctrl.sv
hw/rtl/inverse_distance_weight_row.sv
tb/tb_inverse_distance_weight_row.sv
